// ===== sv/ppjq_pkg.sv =====
// Package for the preemptive priority job queue.
// Holds the queue depth, the request, response and slot types and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package ppjq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      ACT_TICK   = 1'b0,
      ACT_ARRIVE = 1'b1
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  job_id;
      logic [15:0] burst;
      logic [7:0]  priority_req;
   } req_type;

   typedef struct packed {
      logic             done_valid;
      logic [7:0]       done_job;
      logic             running_valid;
      logic [7:0]       running_job;
      logic [OCC_W-1:0] queued_count;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  job;
      logic [15:0] remaining;
      logic [7:0]  prio;
   } slot_type;

   typedef struct packed {
      logic insert;
      logic remove;
      logic dec_head;
   } cell_ctrl_type;

endpackage

// ===== sv/ppjq_cell.sv =====
// One slot of the sorted job queue, a cell in the shift chain.
// Depends on ppjq_pkg for the slot and control types.
`timescale 1ns / 1ps

module ppjq_cell
   import ppjq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          head,
   input  logic          occupied,
   input  logic          prev_stay,
   input  slot_type      new_slot,
   input  slot_type      left_slot,
   input  slot_type      right_slot,
   output slot_type      slot_q,
   output slot_type      slot_next,
   output logic          stay
);

   slot_type slot_ff;
   slot_type slot_in;

   // A queued job stays in place when the arrival has strictly lower priority.
   assign stay = occupied && (new_slot.prio < slot_ff.prio);

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.insert) begin
         if (!stay) begin
            slot_in = prev_stay ? new_slot : left_slot;
         end
      end else if (ctrl.remove) begin
         slot_in = right_slot;
      end else if (ctrl.dec_head && head) begin
         slot_in.remaining = slot_ff.remaining - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_q    = slot_ff;
   assign slot_next = slot_in;

endmodule

// ===== sv/preemptive_priority_job_queue.sv =====
// Preemptive priority job queue, top level.
// Depends on ppjq_pkg and instantiates a row of ppjq_cell slots.
`timescale 1ns / 1ps

// The queue holds up to sixteen jobs in a row of slot cells, sorted with the highest
// priority at the head. Every cell decides its next contents in the same cycle from its
// own slot and its neighbors, so an arrival or a tick is taken every clock cycle while the
// output register is empty or its response is being taken, and the response is loaded into
// the output register in the cycle after the request is accepted. A new request is taken
// while the previous response waits, as long as that response is taken in the same cycle.

module preemptive_priority_job_queue
   import ppjq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic             accept;
   logic             full;
   logic             done;
   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   cell_ctrl_type    ctrl;
   slot_type         new_slot;
   slot_type         slot_q    [QUEUE_DEPTH];
   slot_type         slot_next [QUEUE_DEPTH];
   logic             stay      [QUEUE_DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign done      = (occ_ff != '0) && (slot_q[0].remaining <= 16'd1);

   assign new_slot.job       = req_payload.job_id;
   assign new_slot.remaining = req_payload.burst;
   assign new_slot.prio      = req_payload.priority_req;

   always_comb begin
      ctrl.insert   = accept && (req_payload.action == ACT_ARRIVE) && !full;
      ctrl.remove   = accept && (req_payload.action == ACT_TICK) && done;
      ctrl.dec_head = accept && (req_payload.action == ACT_TICK) && (occ_ff != '0) && !done;
   end

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         slot_type left_slot;
         slot_type right_slot;
         logic     prev_stay;

         if (g == 0) begin : g_first
            assign left_slot = new_slot;
            assign prev_stay = 1'b1;
         end else begin : g_inner
            assign left_slot = slot_q[g-1];
            assign prev_stay = stay[g-1];
         end

         if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_slot = slot_q[g];
         end else begin : g_mid
            assign right_slot = slot_q[g+1];
         end

         ppjq_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .head       (g == 0),
            .occupied   (occ_ff > OCC_W'(g)),
            .prev_stay  (prev_stay),
            .new_slot   (new_slot),
            .left_slot  (left_slot),
            .right_slot (right_slot),
            .slot_q     (slot_q[g]),
            .slot_next  (slot_next[g]),
            .stay       (stay[g])
         );
      end
   endgenerate

   always_comb begin
      occ_in = occ_ff;
      if (ctrl.insert) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (ctrl.remove) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_comb begin
      rsp_in               = rsp_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in         = 1'b1;
         rsp_in.done_valid    = ctrl.remove;
         rsp_in.done_job      = ctrl.remove ? slot_q[0].job : 8'd0;
         rsp_in.running_valid = (occ_in != '0);
         rsp_in.running_job   = (occ_in != '0) ? slot_next[0].job : 8'd0;
         rsp_in.queued_count  = occ_in;
         rsp_in.overflow      = (req_payload.action == ACT_ARRIVE) && full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(QUEUE_DEPTH))
      else $error("queue occupancy exceeds its depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.overflow |-> rsp_ff.queued_count == OCC_W'(QUEUE_DEPTH))
      else $error("overflow reported with room in the queue");

   a_done_not_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.done_valid && rsp_ff.overflow))
      else $error("completion and overflow reported together");

   a_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.running_valid == (rsp_ff.queued_count != '0))
      else $error("running flag disagrees with queue count");

   a_dec_keeps: assert property (@(posedge clock) disable iff (reset)
      ctrl.dec_head |=> $stable(occ_ff))
      else $error("occupancy changed on a plain tick");

endmodule
